// ===== hw/rtl/fir64_pkg.sv =====
// ----------------------------------------------------------------------------
// fir64_pkg
// Shared constants and the fixed Q1.15 coefficient set of the 64-tap FIR.
// ----------------------------------------------------------------------------
package fir64_pkg;

  localparam int Taps     = 64;
  localparam int CoefW    = 16;
  localparam int CoefFrac = 15;
  // log2(Taps): headroom for the sum of all products
  localparam int Growth   = $clog2(Taps);

  typedef logic signed [CoefW-1:0] coef_t;

  localparam coef_t Coefs [Taps] = '{
    16'sd16,    16'sd23,    -16'sd23,   -16'sd25,   16'sd36,    16'sd29,    -16'sd58,
    -16'sd32,   16'sd91,    16'sd29,    -16'sd135,  -16'sd15,   16'sd192,   -16'sd15,
    -16'sd261,  16'sd68,    16'sd338,   -16'sd153,  -16'sd422,  16'sd279,   16'sd508,
    -16'sd463,  -16'sd592,  16'sd730,   16'sd669,   -16'sd1136, -16'sd734,  16'sd1821,
    16'sd784,   -16'sd3313, -16'sd815,  16'sd10375, 16'sd17210, 16'sd10375, -16'sd815,
    -16'sd3313, 16'sd784,   16'sd1821,  -16'sd734,  -16'sd1136, 16'sd669,   16'sd730,
    -16'sd592,  -16'sd463,  16'sd508,   16'sd279,   -16'sd422,  -16'sd153,  16'sd338,
    16'sd68,    -16'sd261,  -16'sd15,   16'sd192,   -16'sd15,   -16'sd135,  16'sd29,
    16'sd91,    -16'sd32,   -16'sd58,   16'sd29,    16'sd36,    -16'sd25,   -16'sd23,
    16'sd23
  };

endpackage

// ===== hw/rtl/fir64_sample_if.sv =====
// ----------------------------------------------------------------------------
// fir64_sample_if
// Valid/ready channel carrying one input sample per request.
// ----------------------------------------------------------------------------
interface fir64_sample_if #(
  parameter int SampleWidth = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SampleWidth-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

// ===== hw/rtl/fir64_filtered_if.sv =====
// ----------------------------------------------------------------------------
// fir64_filtered_if
// Valid/ready channel carrying one filtered sample per request.
// ----------------------------------------------------------------------------
interface fir64_filtered_if #(
  parameter int SampleWidth = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SampleWidth-1:0] filtered;

  modport source (output valid, output filtered, input ready);
  modport sink   (input valid, input filtered, output ready);
endinterface

// ===== hw/rtl/fir_filter_64_tap.sv =====
// ----------------------------------------------------------------------------
// fir_filter_64_tap
// 64-tap low-pass FIR, transposed form built from a chain of tap cells.
// ----------------------------------------------------------------------------
// Takes one signed Q1.(SAMPLE_WIDTH-1) sample per request and returns one
// filtered sample per request in the same format. The tap chain advances on
// every accepted sample, so a new sample can be taken every cycle; the result
// of a sample passes the tap chain registers and then the output register,
// which takes it rounded and saturated. Throughput is one sample per cycle
// as long as the output side takes results; while a result waits, at most
// one more sample is taken. Taps start out at zero after reset.
module fir_filter_64_tap
  import fir64_pkg::*;
#(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  fir64_sample_if.sink             in_i,
  fir64_filtered_if.source         out_o
);

  localparam int AccWidth = SAMPLE_WIDTH + CoefW + Growth;
  localparam int RndWidth = AccWidth - CoefFrac;

  logic                       accept;
  logic                       out_free;
  logic                       pend_d, pend_q;
  logic                       out_valid_d, out_valid_q;
  logic signed [SAMPLE_WIDTH-1:0] out_data_d, out_data_q;

  logic signed [AccWidth-1:0] psum [Taps+1];
  logic signed [AccWidth-1:0] acc_rnd;
  logic signed [RndWidth-1:0] rnd;
  logic                       ovf;
  logic signed [SAMPLE_WIDTH-1:0] sat;

  assign out_free = !out_valid_q || out_o.ready;
  assign in_i.ready = !pend_q || out_free;
  assign accept   = in_i.valid && in_i.ready;

  assign psum[Taps] = '0;

  for (genvar k = 0; k < Taps; k++) begin : g_tap
    fir64_cell #(
      .SampleWidth (SAMPLE_WIDTH),
      .AccWidth    (AccWidth)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .en_i     (accept),
      .sample_i (in_i.sample),
      .coef_i   (Coefs[k]),
      .psum_i   (psum[k+1]),
      .psum_o   (psum[k])
    );
  end

  // round half up, then saturate
  assign acc_rnd = psum[0] + (AccWidth'(1) <<< (CoefFrac - 1));
  assign rnd     = acc_rnd[AccWidth-1:CoefFrac];
  assign ovf     = !((&rnd[RndWidth-1:SAMPLE_WIDTH-1]) || !(|rnd[RndWidth-1:SAMPLE_WIDTH-1]));
  assign sat     = ovf ? (rnd[RndWidth-1] ? {1'b1, {(SAMPLE_WIDTH-1){1'b0}}}
                                          : {1'b0, {(SAMPLE_WIDTH-1){1'b1}}})
                       : rnd[SAMPLE_WIDTH-1:0];

  always_comb begin
    pend_d      = pend_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (pend_q && out_free) begin
      out_valid_d = 1'b1;
      out_data_d  = sat;
      pend_d      = 1'b0;
    end
    if (accept) begin
      pend_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.filtered = out_data_q;

  a_accept_pends : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> pend_q)
    else $error("accepted request not marked pending");

  a_pend_to_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q && out_free |=> out_valid_q)
    else $error("pending result not moved to output");

  a_acc_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q && !out_free |=> pend_q && $stable(psum[0]))
    else $error("accumulator changed while result pending");

endmodule

// ===== hw/rtl/fir64_cell.sv =====
// ----------------------------------------------------------------------------
// fir64_cell
// One tap of the transposed FIR: multiplies the incoming sample by its
// coefficient and adds the partial sum handed over by the next older tap.
// ----------------------------------------------------------------------------
module fir64_cell
  import fir64_pkg::*;
#(
  parameter int SampleWidth = 16,
  parameter int AccWidth    = 38
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic signed [SampleWidth-1:0] sample_i,
  input  coef_t                      coef_i,
  input  logic signed [AccWidth-1:0] psum_i,
  output logic signed [AccWidth-1:0] psum_o
);

  localparam int ProdW = SampleWidth + CoefW;

  logic signed [ProdW-1:0]    prod;
  logic signed [AccWidth-1:0] psum_d, psum_q;

  assign prod   = ProdW'(sample_i) * ProdW'(coef_i);
  assign psum_d = AccWidth'(prod) + psum_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      psum_q <= '0;
    end else if (en_i) begin
      psum_q <= psum_d;
    end
  end

  assign psum_o = psum_q;

endmodule
